@@ rtl/core/sorted_priority_queue_assert.svh @@
// Assertion macros for the sorted priority queue RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed: label");
`else
`define SPQ_ASSERT_IMPL(label, clk, rst, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;
   localparam int DEPTH_DEF     = 16;
   localparam int TAG_BITS_DEF  = 32;
   localparam int PRIO_BITS_DEF = 16;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_CHANGE = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Commands from the controller to the cell array.
   typedef struct packed {
      logic load;     // latch the request operands
      logic insert;   // insert the latched operands in order
      logic del_tag;  // remove the first entry whose tag matches
      logic del_prio; // remove the first entry whose priority matches
      logic pop;      // remove the head
      logic rd_clr;   // reset the read-out pointer
      logic rd_next;  // advance the read-out pointer
   } cmd_type;

   // Status from the cell array to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic tag_hit;
      logic prio_hit;
      logic rd_last;
   } stat_type;
endpackage

@@ rtl/core/spq_cells.sv @@
// Datapath: a row of sorted cells that compare and shift in parallel.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"
module spq_cells #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEF,
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cmd_type      cmd,
   input  logic [PRIO_BITS-1:0]  in_prio,
   input  logic [TAG_BITS-1:0]   in_tag,
   output spq_pkg::stat_type     stat,
   output logic [PRIO_BITS-1:0]  head_prio,
   output logic [TAG_BITS-1:0]   head_tag,
   output logic [PRIO_BITS-1:0]  rd_prio,
   output logic [TAG_BITS-1:0]   rd_tag
);
   import spq_pkg::*;
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [PRIO_BITS-1:0] prio_ff [DEPTH];
   logic [TAG_BITS-1:0]  tag_ff  [DEPTH];
   logic [PRIO_BITS-1:0] prio_in [DEPTH];
   logic [TAG_BITS-1:0]  tag_in  [DEPTH];
   logic [DEPTH-1:0]     used_ff, used_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PRIO_BITS-1:0] op_prio_ff;
   logic [TAG_BITS-1:0]  op_tag_ff;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;

   logic [DEPTH-1:0] le_vec, tag_eq, prio_eq, tag_first, prio_first, del_vec, del_after;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le_vec[i]  = used_ff[i] &&
            ($signed(prio_ff[i]) <= $signed(op_prio_ff));
         tag_eq[i]  = used_ff[i] && (tag_ff[i] == op_tag_ff);
         prio_eq[i] = used_ff[i] && (prio_ff[i] == op_prio_ff);
      end
      // Lowest set bit of each match vector, and everything at or above it.
      tag_first  = tag_eq & (~tag_eq + 1'b1);
      prio_first = prio_eq & (~prio_eq + 1'b1);
      del_vec = '0;
      if (cmd.pop) del_vec = {{(DEPTH-1){1'b0}}, 1'b1};
      else if (cmd.del_tag) del_vec = tag_first;
      else if (cmd.del_prio) del_vec = prio_first;
      del_after = del_vec | ((del_vec - 1'b1) ^ {DEPTH{1'b1}}) & ~{DEPTH{del_vec == '0}};
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         prio_in[i] = prio_ff[i];
         tag_in[i]  = tag_ff[i];
      end
      used_in  = used_ff;
      count_in = count_ff;
      if (cmd.insert) begin
         // Cells above the last entry that is not greater shift up one place.
         for (int i = 0; i < DEPTH; i++) begin
            if (!le_vec[i]) begin
               if (i == 0 || le_vec[(i == 0) ? 0 : i-1]) begin
                  prio_in[i] = op_prio_ff;
                  tag_in[i]  = op_tag_ff;
               end else begin
                  prio_in[i] = prio_ff[(i == 0) ? 0 : i-1];
                  tag_in[i]  = tag_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
         used_in  = {used_ff[DEPTH-2:0], 1'b1};
         count_in = count_ff + 1'b1;
      end else if (del_vec != '0) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (del_after[i]) begin
               if (i == DEPTH-1) begin
                  prio_in[i] = prio_ff[i];
                  tag_in[i]  = tag_ff[i];
               end else begin
                  prio_in[i] = prio_ff[(i == DEPTH-1) ? i : i+1];
                  tag_in[i]  = tag_ff[(i == DEPTH-1) ? i : i+1];
               end
            end
         end
         used_in  = {1'b0, used_ff[DEPTH-1:1]};
         count_in = count_ff - 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (cmd.rd_clr) rd_ptr_in = '0;
      else if (cmd.rd_next) rd_ptr_in = rd_ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         prio_ff[i] <= prio_in[i];
         tag_ff[i]  <= tag_in[i];
      end
      if (cmd.load) begin
         op_prio_ff <= in_prio;
         op_tag_ff  <= in_tag;
      end else if (cmd.del_tag) begin
         // A priority change keeps the matched tag for its reinsert.
         op_tag_ff <= op_tag_ff;
      end
      if (reset) begin
         used_ff   <= '0;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
      end else begin
         used_ff   <= used_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.tag_hit  = (tag_eq != '0);
   assign stat.prio_hit = (prio_eq != '0);
   assign stat.rd_last  = (rd_ptr_ff + 1'b1 == count_ff);
   assign head_prio = prio_ff[0];
   assign head_tag  = tag_ff[0];
   assign rd_prio   = prio_ff[rd_ptr_ff[IW-1:0]];
   assign rd_tag    = tag_ff[rd_ptr_ff[IW-1:0]];

   // Used cells always form a contiguous run from the head.
   `SPQ_ASSERT_IMPL(a_used_packed, clock, reset, (used_ff & (used_ff + 1'b1)) == '0)
   `SPQ_ASSERT_IMPL(a_count_match, clock, reset, $countones(used_ff) == int'(count_ff))
   `SPQ_ASSERT_IMPL(a_no_ins_full, clock, reset, !(cmd.insert && stat.full))
endmodule

@@ rtl/core/spq_ctrl.sv @@
// Controller: request sequencing and response generation.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"
module spq_ctrl #(
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   output spq_pkg::cmd_type     cmd,
   input  spq_pkg::stat_type    stat,
   input  logic [PRIO_BITS-1:0] head_prio,
   input  logic [TAG_BITS-1:0]  head_tag,
   input  logic [PRIO_BITS-1:0] rd_prio,
   input  logic [TAG_BITS-1:0]  rd_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [PRIO_BITS-1:0] rsp_out_prio,
   output logic [TAG_BITS-1:0]  rsp_out_tag,
   output logic                 rsp_last
);
   import spq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_REIN = 5'b00100,
      S_READ = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] op_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [PRIO_BITS-1:0] oprio_ff, oprio_in;
   logic [TAG_BITS-1:0]  otag_ff, otag_in;
   logic       last_ff, last_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      oprio_in     = oprio_ff;
      otag_in      = otag_ff;
      last_in      = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               oprio_in     = '0;
               otag_in      = '0;
               last_in      = 1'b1;
               state_in     = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (stat.full) status_in = ST_FULL;
                     else cmd.insert = 1'b1;
                  end
                  OP_REMOVE: begin
                     if (stat.empty) status_in = ST_EMPTY;
                     else begin
                        cmd.pop  = 1'b1;
                        oprio_in = head_prio;
                        otag_in  = head_tag;
                     end
                  end
                  OP_CHANGE: begin
                     if (stat.empty) status_in = ST_EMPTY;
                     else if (!stat.tag_hit) status_in = ST_NOTFOUND;
                     else begin
                        cmd.del_tag  = 1'b1;
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        state_in     = S_REIN;
                     end
                  end
                  OP_DELETE: begin
                     if (stat.empty) status_in = ST_EMPTY;
                     else if (!stat.prio_hit) status_in = ST_NOTFOUND;
                     else cmd.del_prio = 1'b1;
                  end
                  OP_READ: begin
                     if (stat.empty) status_in = ST_EMPTY;
                     else begin
                        cmd.rd_clr   = 1'b1;
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        state_in     = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_REIN: begin
            cmd.insert   = 1'b1;
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            oprio_in     = '0;
            otag_in      = '0;
            last_in      = 1'b1;
            state_in     = S_RESP;
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               oprio_in     = rd_prio;
               otag_in      = rd_tag;
               last_in      = stat.rd_last;
               cmd.rd_next  = 1'b1;
               if (stat.rd_last) state_in = S_IDLE;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) op_ff <= req_opcode;
      status_ff <= status_in;
      oprio_ff  <= oprio_in;
      otag_ff   <= otag_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_out_prio = oprio_ff;
   assign rsp_out_tag  = otag_ff;
   assign rsp_last     = last_ff;

   `SPQ_ASSERT_IMPL(a_onehot_state, clock, reset, $onehot(state_ff))
   `SPQ_ASSERT_IMPL(a_rein_after_del, clock, reset, (state_ff == S_REIN) |-> $past(cmd.del_tag))
   `SPQ_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready |-> (state_ff == S_IDLE))
endmodule

@@ rtl/core/sorted_priority_queue.sv @@
// Top level of the sorted priority queue.
// Depends on spq_pkg, spq_ctrl and spq_cells.
//
// A bounded queue of tagged entries kept in ascending priority, ties in
// arrival order. Requests are taken one at a time. Insert, remove, delete
// and unknown opcodes are accepted in the idle state and answered from
// the execute state, which registers the response, before the controller
// returns to idle. For a priority change the cell row removes the entry
// in the execute state, then reinserts it in the reinsert state, which
// registers the response, and the controller passes through a response
// state before it returns to idle. A read-out clears the read pointer in
// the execute state, then presents one response per cycle while the
// response side does not stall, with the last one flagged. Stalls on the
// response side hold the execute and read-out states. All cells compare
// and shift in parallel, so no operation steps through them one by one.
module sorted_priority_queue #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEF,
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   input  logic [PRIO_BITS-1:0] req_prio,
   input  logic [TAG_BITS-1:0]  req_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [PRIO_BITS-1:0] rsp_out_prio,
   output logic [TAG_BITS-1:0]  rsp_out_tag,
   output logic                 rsp_last
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [PRIO_BITS-1:0] head_prio, rd_prio;
   logic [TAG_BITS-1:0]  head_tag, rd_tag;

   spq_ctrl #(.TAG_BITS(TAG_BITS), .PRIO_BITS(PRIO_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode,
      .cmd, .stat, .head_prio, .head_tag, .rd_prio, .rd_tag,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_out_prio, .rsp_out_tag, .rsp_last
   );

   spq_cells #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS), .PRIO_BITS(PRIO_BITS)) u_cells (
      .clock, .reset, .cmd, .in_prio(req_prio), .in_tag(req_tag), .stat,
      .head_prio, .head_tag, .rd_prio, .rd_tag
   );
endmodule
